>>> rtl/dxt_pkg.sv
package dxt_pkg;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 40;

  // colour palette as argb8888 and the eight-entry alpha table
  typedef struct packed {
    logic [3:0][31:0] color;
    logic [7:0][7:0]  alpha;
  } dxt_pal_t;

  // everything the pixel sequencer needs for one block
  typedef struct packed {
    dxt_pal_t    pal;
    logic [31:0] cidx;
    logic [63:0] abits;
  } dxt_blk_t;

  // reciprocal multiply, exact for x below 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] prod;
    prod = {11'd0, x} * 21'd683;
    return prod[18:11];
  endfunction

  // exact for x below 1792
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] prod;
    prod = {12'd0, x} * 23'd2341;
    return prod[21:14];
  endfunction

  // exact for x below 1280
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] prod;
    prod = {12'd0, x} * 23'd3277;
    return prod[21:14];
  endfunction

endpackage

>>> rtl/dxt_palette.sv
module dxt_palette (
  input  logic [31:0]      color_ends,
  input  logic [15:0]      alpha_ends,
  output dxt_pkg::dxt_pal_t pal
);

  logic [15:0] c0, c1;
  logic [7:0]  r0, g0, b0, r1, g1, b1;
  logic [7:0]  a0, a1;
  logic [10:0] s7 [1:6];
  logic [10:0] s5 [1:4];

  // two thirds of a plus one third of b, rounded down
  function automatic logic [7:0] mix3(input logic [7:0] a, input logic [7:0] b);
    return dxt_pkg::div3({1'b0, a, 1'b0} + {2'b00, b});
  endfunction

  function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  assign c0 = color_ends[15:0];
  assign c1 = color_ends[31:16];
  assign r0 = {c0[15:11], 3'b000};
  assign g0 = {c0[10:5], 2'b00};
  assign b0 = {c0[4:0], 3'b000};
  assign r1 = {c1[15:11], 3'b000};
  assign g1 = {c1[10:5], 2'b00};
  assign b1 = {c1[4:0], 3'b000};
  assign a0 = alpha_ends[7:0];
  assign a1 = alpha_ends[15:8];

  always_comb begin
    for (int i = 1; i <= 6; i++) begin
      s7[i] = 11'(7 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
    end
    for (int i = 1; i <= 4; i++) begin
      s5[i] = 11'(5 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
    end
  end

  always_comb begin
    pal.color[0] = {8'hff, r0, g0, b0};
    pal.color[1] = {8'hff, r1, g1, b1};
    if (c0 > c1) begin
      pal.color[2] = {8'hff, mix3(r0, r1), mix3(g0, g1), mix3(b0, b1)};
      pal.color[3] = {8'hff, mix3(r1, r0), mix3(g1, g0), mix3(b1, b0)};
    end else begin
      // three-colour mode, index 3 is transparent black
      pal.color[2] = {8'hff, half(r0, r1), half(g0, g1), half(b0, b1)};
      pal.color[3] = 32'h0000_0000;
    end

    pal.alpha[0] = a0;
    pal.alpha[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) begin
        pal.alpha[3'(i + 1)] = dxt_pkg::div7(s7[i]);
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        pal.alpha[3'(i + 1)] = dxt_pkg::div5(s5[i]);
      end
      pal.alpha[6] = 8'h00;
      pal.alpha[7] = 8'hff;
    end
  end

endmodule

>>> rtl/dxt_pixel_seq.sv
module dxt_pixel_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        fmt,
  input  logic              blk_valid,
  input  dxt_pkg::dxt_blk_t blk,
  output logic              blk_take,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [dxt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic              out_tlast
);

  logic              busy_r;
  logic [3:0]        cnt_r;
  dxt_pkg::dxt_pal_t pal_r;
  logic [31:0]       cidx_r;
  logic [63:0]       abits_r;
  logic              out_valid_r;
  logic [31:0]       out_argb_r;
  logic [3:0]        out_pos_r;
  logic              out_last_r;

  logic        emit;
  logic        done;
  logic [31:0] px;

  assign emit     = busy_r && (!out_valid_r || out_tready);
  assign done     = emit && (&cnt_r);
  assign blk_take = blk_valid && (!busy_r || done);

  always_comb begin
    px = pal_r.color[cidx_r[1:0]];
    case (fmt)
      dxt_pkg::FMT_DXT3: px[31:24] = {abits_r[3:0], abits_r[3:0]};
      dxt_pkg::FMT_DXT5: px[31:24] = pal_r.alpha[abits_r[2:0]];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (blk_take) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // index words shift down one pixel per emitted transaction
  always_ff @(posedge clk) begin
    if (blk_take) begin
      pal_r  <= blk.pal;
      cidx_r <= blk.cidx;
      cnt_r  <= 4'd0;
      if (fmt == dxt_pkg::FMT_DXT5) begin
        abits_r <= {16'd0, blk.abits[63:16]};
      end else begin
        abits_r <= blk.abits;
      end
    end else if (emit) begin
      cnt_r  <= cnt_r + 4'd1;
      cidx_r <= {2'b00, cidx_r[31:2]};
      if (fmt == dxt_pkg::FMT_DXT5) begin
        abits_r <= {3'b000, abits_r[63:3]};
      end else begin
        abits_r <= {4'h0, abits_r[63:4]};
      end
    end
    if (emit) begin
      out_argb_r <= px;
      out_pos_r  <= cnt_r;
      out_last_r <= &cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_pos_r[1:0], out_pos_r[3:2], out_argb_r};
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/dxt_texture_block_decoder_top.sv
// channel  | dir | tvalid/tready/we        | payload
// in_      | in  | in_tvalid, in_tready    | in_tdata: alpha_block 63:0, color_block 127:64
// out_     | out | out_tvalid, out_tready  | out_tdata: argb 31:0, row 33:32, column 35:34
//          |     |                         | out_tlast: last pixel of the block
// cfg_     | in  | cfg_we                  | cfg_wdata: block_format
//
// each block gives 16 pixel transactions, one per cycle while out_tready stays high; the
// pixel sequencer steps once per pixel and takes the next block as its last pixel goes out
// on its way to out_ a block passes the input, sequencer and output registers
// reset clears all valid flags and sets block_format to dxt1
// a low out_tready holds the output and pauses the sequencer; one further block waits in
// the input register, then in_tready drops
module dxt_texture_block_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,   // block_format
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [dxt_pkg::IN_DATA_W-1:0]  in_tdata,   // alpha_block, color_block
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [dxt_pkg::OUT_DATA_W-1:0] out_tdata,  // pixel_argb, pixel_row, pixel_column
  output logic        out_tlast    // last_pixel
);

  logic [1:0]        format_r;
  logic              in_valid_r;
  logic [63:0]       alpha_r;
  logic [63:0]       color_r;
  logic              blk_take;
  dxt_pkg::dxt_pal_t pal;
  dxt_pkg::dxt_blk_t blk;

  assign in_tready = !in_valid_r || blk_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r   <= dxt_pkg::FMT_DXT1;
      in_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        format_r <= cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (blk_take) begin
        in_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      alpha_r <= in_tdata[63:0];
      color_r <= in_tdata[127:64];
    end
  end

  dxt_palette u_palette (
    .color_ends (color_r[31:0]),
    .alpha_ends (alpha_r[15:0]),
    .pal        (pal)
  );

  assign blk = {pal, color_r[63:32], alpha_r};

  dxt_pixel_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .fmt        (format_r),
    .blk_valid  (in_valid_r),
    .blk        (blk),
    .blk_take   (blk_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/dxt_checker.sv
module dxt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [dxt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic        out_tlast
);

  logic [3:0] pos_r;

  // expected position of the next pixel transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
    end else if (out_tvalid && out_tready) begin
      pos_r <= pos_r + 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_pixel_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:32] == pos_r[3:2] && out_tdata[35:34] == pos_r[1:0])
    else $error("pixel out of row order");

  a_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == (out_tdata[35:32] == 4'hf))
    else $error("tlast not on the sixteenth pixel");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:36] == 4'h0)
    else $error("tdata padding not zero");

endmodule

bind dxt_texture_block_decoder_top dxt_checker u_dxt_checker (.*);
